// ----- rtl/srm_pkg.sv -----
package srm_pkg;

   localparam int CAPACITY        = 1024;
   localparam int IDX_BITS        = $clog2(CAPACITY);
   localparam int CNT_BITS        = IDX_BITS + 1;
   localparam int VALUE_BITS      = 32;
   localparam int LEVELS          = 11;
   localparam int LVL_BITS        = $clog2(LEVELS);
   localparam int STEP_BITS       = $clog2(LEVELS + 1);
   localparam int TABLE_DEPTH     = LEVELS * CAPACITY;
   localparam int TABLE_ADDR_BITS = LVL_BITS + IDX_BITS;
   localparam int REQ_BITS        = 2;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS       = $clog2(QUEUE_DEPTH + 1);

   localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

   typedef enum logic [REQ_BITS-1:0] {
      REQ_CLEAR = 2'd0,
      REQ_LOAD  = 2'd1,
      REQ_QUERY = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_QUERY,
      CMD_EMPTY
   } cmd_op_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_LOAD,
      BACK_QUERY
   } back_state_type;

   typedef struct packed {
      logic [REQ_BITS-1:0]          req_type;
      logic signed [VALUE_BITS-1:0] value;
      logic [IDX_BITS-1:0]          left;
      logic [IDX_BITS-1:0]          right;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] min_value;
      logic [IDX_BITS-1:0]          min_index;
      logic                         empty_res;
   } rsp_payload_type;

   typedef struct packed {
      cmd_op_type                   op;
      logic signed [VALUE_BITS-1:0] value;
      logic [IDX_BITS-1:0]          pos;
      logic [IDX_BITS-1:0]          pos2;
      logic [LVL_BITS-1:0]          lvl;
   } cmd_entry_type;

endpackage

// ----- rtl/sparse_table_range_min.sv -----
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   req_data  (req_payload_type)
// rsp      out        rsp_valid/rsp_stall   rsp_data  (rsp_payload_type)
//
// The front feeds a four-entry command queue one transaction a cycle while it has room;
// clears and dropped loads end in the front. A load merges one argmin level per cycle
// through the pipelined table and value RAM reads up to lvl = floor(log2(position + 1))
// capped at LEVELS - 1. A query reads its two table entries in turn through the single
// read port of the argmin RAM; an empty query skips the table. Reset clears only control
// state and the count; the RAMs need no clearing pass. A stalled result holds the back end
// before its next query, while loads keep going and the queue absorbs new transactions.
module sparse_table_range_min (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  srm_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output srm_pkg::rsp_payload_type rsp_data
);
   import srm_pkg::*;

   logic          push;
   cmd_entry_type push_data;
   logic          q_full;
   logic          q_empty;
   logic          pop;
   cmd_entry_type head;

   srm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .push      (push),
      .push_data (push_data),
      .q_full    (q_full)
   );

   srm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (head),
      .empty     (q_empty)
   );

   srm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- rtl/srm_ram.sv -----
module srm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/srm_front.sv -----
module srm_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  srm_pkg::req_payload_type req_data,
   output logic                    push,
   output srm_pkg::cmd_entry_type  push_data,
   input  logic                    q_full
);
   import srm_pkg::*;

   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;
   logic                accept;
   logic                empty_range;
   logic [CNT_BITS-1:0] left_ext;
   logic [CNT_BITS-1:0] right_ext;
   logic [CNT_BITS-1:0] right_clamp;
   logic [CNT_BITS-1:0] span_len;
   logic [CNT_BITS-1:0] load_len;
   logic [LVL_BITS-1:0] query_lvl;
   logic [LVL_BITS-1:0] load_lvl;
   logic [CNT_BITS-1:0] second_start;

   function automatic logic [LVL_BITS-1:0] level_of(input logic [CNT_BITS-1:0] x);
      logic [LVL_BITS-1:0] k;
      k = '0;
      for (int i = 1; i < LEVELS; i++) begin
         if (x >= (CNT_BITS'(1) << i)) begin
            k = LVL_BITS'(i);
         end
      end
      return k;
   endfunction

   assign accept    = req_valid && !q_full;
   assign req_stall = q_full;

   always_comb begin
      left_ext     = {1'b0, req_data.left};
      right_ext    = {1'b0, req_data.right};
      empty_range  = (req_data.left > req_data.right) || (left_ext >= count_ff);
      right_clamp  = (right_ext >= count_ff) ? count_ff - CNT_BITS'(1) : right_ext;
      span_len     = right_clamp - left_ext + CNT_BITS'(1);
      query_lvl    = level_of(span_len);
      second_start = right_clamp + CNT_BITS'(1) - (CNT_BITS'(1) << query_lvl);
      load_len     = count_ff + CNT_BITS'(1);
      load_lvl     = level_of(load_len);
   end

   always_comb begin
      count_in  = count_ff;
      push      = 1'b0;
      push_data = '{op: CMD_EMPTY, value: req_data.value, pos: req_data.left,
                    pos2: second_start[IDX_BITS-1:0], lvl: query_lvl};
      if (accept) begin
         unique case (req_code_type'(req_data.req_type))
            REQ_CLEAR: begin
               count_in = '0;
            end
            REQ_LOAD: begin
               if (count_ff < CNT_BITS'(CAPACITY)) begin
                  push          = 1'b1;
                  push_data.op  = CMD_LOAD;
                  push_data.pos = count_ff[IDX_BITS-1:0];
                  push_data.lvl = load_lvl;
                  count_in      = load_len;
               end
            end
            REQ_QUERY: begin
               push         = 1'b1;
               push_data.op = empty_range ? CMD_EMPTY : CMD_QUERY;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/srm_queue.sv -----
module srm_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  srm_pkg::cmd_entry_type push_data,
   output logic                   full,
   input  logic                   pop,
   output srm_pkg::cmd_entry_type pop_data,
   output logic                   empty
);
   import srm_pkg::*;

   cmd_entry_type        slots_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff;
   logic [QPTR_BITS-1:0] wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff;
   logic [QPTR_BITS-1:0] rd_ptr_in;
   logic [QCNT_BITS-1:0] fill_ff;
   logic [QCNT_BITS-1:0] fill_in;

   assign full     = (fill_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign empty    = (fill_ff == '0);
   assign pop_data = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      fill_in   = fill_ff + QCNT_BITS'(push) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/srm_back.sv -----
module srm_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_empty,
   input  srm_pkg::cmd_entry_type   head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output srm_pkg::rsp_payload_type rsp_data
);
   import srm_pkg::*;

   localparam logic [STEP_BITS-1:0] Q_READ_A  = STEP_BITS'(0);
   localparam logic [STEP_BITS-1:0] Q_READ_B  = STEP_BITS'(1);
   localparam logic [STEP_BITS-1:0] Q_FETCH_B = STEP_BITS'(2);
   localparam logic [STEP_BITS-1:0] Q_PICK    = STEP_BITS'(3);
   localparam logic [STEP_BITS-1:0] L_FIRST_MERGE = STEP_BITS'(2);

   back_state_type        state_ff;
   back_state_type        state_in;
   logic [STEP_BITS-1:0]  t_ff;
   logic [STEP_BITS-1:0]  t_in;
   cmd_entry_type         cmd_ff;
   cmd_entry_type         cmd_in;
   logic [IDX_BITS-1:0]   a_ff;
   logic [IDX_BITS-1:0]   a_in;
   logic [IDX_BITS-1:0]   b_ff;
   logic [IDX_BITS-1:0]   b_in;
   logic [IDX_BITS-1:0]   best_ff;
   logic [IDX_BITS-1:0]   best_in;
   logic [VALUE_BITS-1:0] best_val_ff;
   logic [VALUE_BITS-1:0] best_val_in;
   logic [VALUE_BITS-1:0] val_a_ff;
   logic [VALUE_BITS-1:0] val_a_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_payload_type       rsp_data_ff;
   rsp_payload_type       rsp_data_in;
   logic [STEP_BITS-1:0]  load_last;
   logic [LVL_BITS-1:0]   issue_lvl;
   logic [LVL_BITS-1:0]   merge_lvl;
   logic                  left_less;

   logic                       val_we;
   logic [IDX_BITS-1:0]        val_waddr;
   logic [VALUE_BITS-1:0]      val_wdata;
   logic [IDX_BITS-1:0]        val_raddr;
   logic [VALUE_BITS-1:0]      val_rdata;
   logic                       tab_we;
   logic [TABLE_ADDR_BITS-1:0] tab_waddr;
   logic [IDX_BITS-1:0]        tab_wdata;
   logic [TABLE_ADDR_BITS-1:0] tab_raddr;
   logic [IDX_BITS-1:0]        tab_rdata;

   function automatic logic [IDX_BITS-1:0] window_start(input logic [IDX_BITS-1:0] last,
                                                        input logic [LVL_BITS-1:0] k);
      logic [CNT_BITS-1:0] s;
      s = {1'b0, last} + CNT_BITS'(1) - (CNT_BITS'(1) << k);
      return s[IDX_BITS-1:0];
   endfunction

   srm_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_values (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_waddr),
      .wr_data (val_wdata),
      .rd_addr (val_raddr),
      .rd_data (val_rdata)
   );

   srm_ram #(.WIDTH(IDX_BITS), .DEPTH(TABLE_DEPTH)) u_argmin (
      .clock   (clock),
      .wr_en   (tab_we),
      .wr_addr (tab_waddr),
      .wr_data (tab_wdata),
      .rd_addr (tab_raddr),
      .rd_data (tab_rdata)
   );

   assign load_last = STEP_BITS'(cmd_ff.lvl) + STEP_BITS'(1);
   assign issue_lvl = LVL_BITS'(t_ff + STEP_BITS'(1));
   assign merge_lvl = LVL_BITS'(t_ff - STEP_BITS'(1));
   assign pop       = (state_ff == BACK_IDLE) && !q_empty &&
                      ((head.op == CMD_LOAD) || !rsp_valid_ff);

   always_comb begin
      state_in = state_ff;
      t_in     = t_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            t_in = '0;
            if (pop && (head.op == CMD_LOAD)) begin
               state_in = BACK_LOAD;
            end else if (pop && (head.op == CMD_QUERY)) begin
               state_in = BACK_QUERY;
            end
         end
         BACK_LOAD: begin
            if (t_ff == load_last) begin
               state_in = BACK_IDLE;
            end else begin
               t_in = t_ff + STEP_BITS'(1);
            end
         end
         BACK_QUERY: begin
            if (t_ff == Q_PICK) begin
               state_in = BACK_IDLE;
            end else begin
               t_in = t_ff + STEP_BITS'(1);
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd_in       = pop ? head : cmd_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      best_in      = best_ff;
      best_val_in  = best_val_ff;
      val_a_in     = val_a_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      val_we       = 1'b0;
      val_waddr    = cmd_ff.pos;
      val_wdata    = cmd_ff.value;
      val_raddr    = tab_rdata;
      tab_we       = 1'b0;
      tab_waddr    = {LVL_BITS'(0), cmd_ff.pos};
      tab_wdata    = cmd_ff.pos;
      tab_raddr    = {cmd_ff.lvl, cmd_ff.pos};
      left_less    = 1'b0;
      unique case (state_ff)
         BACK_IDLE: begin
            if (pop && (head.op == CMD_EMPTY)) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{min_value: VALUE_MAX, min_index: '0, empty_res: 1'b1};
            end
         end
         BACK_LOAD: begin
            a_in = tab_rdata;
            if (t_ff < STEP_BITS'(cmd_ff.lvl)) begin
               tab_raddr = {t_ff[LVL_BITS-1:0], window_start(cmd_ff.pos, issue_lvl)};
            end
            if (t_ff == '0) begin
               val_we      = 1'b1;
               tab_we      = 1'b1;
               best_in     = cmd_ff.pos;
               best_val_in = cmd_ff.value;
            end else if (t_ff >= L_FIRST_MERGE) begin
               left_less   = $signed(val_rdata) < $signed(best_val_ff);
               best_in     = left_less ? a_ff : best_ff;
               best_val_in = left_less ? val_rdata : best_val_ff;
               tab_we      = 1'b1;
               tab_waddr   = {merge_lvl, window_start(cmd_ff.pos, merge_lvl)};
               tab_wdata   = best_in;
            end
         end
         BACK_QUERY: begin
            case (t_ff)
               Q_READ_A: begin
                  tab_raddr = {cmd_ff.lvl, cmd_ff.pos};
               end
               Q_READ_B: begin
                  tab_raddr = {cmd_ff.lvl, cmd_ff.pos2};
                  a_in      = tab_rdata;
               end
               Q_FETCH_B: begin
                  b_in     = tab_rdata;
                  val_a_in = val_rdata;
               end
               Q_PICK: begin
                  left_less    = $signed(val_a_ff) < $signed(val_rdata);
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{min_value: left_less ? val_a_ff : val_rdata,
                                   min_index: left_less ? a_ff : b_ff,
                                   empty_res: 1'b0};
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         t_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         t_ff         <= t_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      best_ff     <= best_in;
      best_val_ff <= best_val_in;
      val_a_ff    <= val_a_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- tb/sparse_table_range_min_tb.sv -----
module sparse_table_range_min_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import srm_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int TAIL_CYCLES = 100;
   localparam int IDX_MAX     = CAPACITY - 1;

   localparam logic [REQ_BITS-1:0]          REQ_UNUSED = 2'd3;
   localparam logic signed [VALUE_BITS-1:0] VALUE_MIN  = {1'b1, {(VALUE_BITS-1){1'b0}}};

   logic            clock;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;

   logic            req_fire  = 1'b0;
   int              send_idle_pct = 9;
   int              rsp_idle_pct  = 64;
   int              error_count   = 0;
   int              cycle_count   = 0;
   int              planned_count = 0;

   req_payload_type pending_requests[$];
   rsp_payload_type expected_minima[$];
   rsp_payload_type want;

   logic signed [VALUE_BITS-1:0] shadow_values [CAPACITY];
   logic [IDX_BITS-1:0]          shadow_argmin [LEVELS][CAPACITY];
   int                           shadow_count = 0;

   sparse_table_range_min u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [IDX_BITS-1:0] lesser_pos(input logic [IDX_BITS-1:0] p,
                                                      input logic [IDX_BITS-1:0] q);
      return (shadow_values[p] < shadow_values[q]) ? p : q;
   endfunction

   task automatic predict_range_min(input req_payload_type t);
      int                  p;
      int                  k;
      int                  j;
      int                  hi;
      int                  span;
      logic [IDX_BITS-1:0] a;
      logic [IDX_BITS-1:0] b;
      logic [IDX_BITS-1:0] idx;
      rsp_payload_type     r;
      case (t.req_type)
         REQ_CLEAR: shadow_count = 0;
         REQ_LOAD: begin
            if (shadow_count < CAPACITY) begin
               p = shadow_count;
               shadow_values[p] = t.value;
               shadow_argmin[0][p] = IDX_BITS'(p);
               for (k = 1; k < LEVELS && (1 << k) <= p + 1; k++) begin
                  j = p + 1 - (1 << k);
                  shadow_argmin[k][j] = lesser_pos(shadow_argmin[k-1][j],
                                                   shadow_argmin[k-1][j + (1 << (k - 1))]);
               end
               shadow_count = p + 1;
            end
         end
         REQ_QUERY: begin
            if (t.left > t.right || int'(t.left) >= shadow_count) begin
               r.min_value = VALUE_MAX;
               r.min_index = '0;
               r.empty_res = 1'b1;
            end else begin
               hi   = (int'(t.right) >= shadow_count) ? shadow_count - 1 : int'(t.right);
               span = hi - int'(t.left) + 1;
               k    = 0;
               while (k + 1 < LEVELS && (span >> (k + 1)) != 0) k++;
               a   = shadow_argmin[k][t.left];
               b   = shadow_argmin[k][hi + 1 - (1 << k)];
               idx = lesser_pos(a, b);
               r.min_value = shadow_values[idx];
               r.min_index = idx;
               r.empty_res = 1'b0;
            end
            expected_minima.insert(expected_minima.size(), r);
         end
         default: ;
      endcase
   endtask

   // driver: advance on a taken transaction or an idle slot, hold while stalled
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_data  <= pending_requests.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
   end

   // monitor
   always @(posedge clock) begin
      req_fire <= req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) predict_range_min(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_minima.size() == 0) begin
               $error("unexpected result: min_value %0d min_index %0d empty_res %0d",
                      rsp_data.min_value, rsp_data.min_index, rsp_data.empty_res);
               error_count = error_count + 1;
            end else begin
               want = expected_minima.pop_front();
               if (rsp_data.min_value !== want.min_value) begin
                  $error("min_value expected %0d got %0d", want.min_value, rsp_data.min_value);
                  error_count = error_count + 1;
               end
               if (rsp_data.min_index !== want.min_index) begin
                  $error("min_index expected %0d got %0d", want.min_index, rsp_data.min_index);
                  error_count = error_count + 1;
               end
               if (rsp_data.empty_res !== want.empty_res) begin
                  $error("empty_res expected %0d got %0d", want.empty_res, rsp_data.empty_res);
                  error_count = error_count + 1;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic add_request(input logic [REQ_BITS-1:0] code,
                              input logic signed [VALUE_BITS-1:0] v,
                              input int l, input int r);
      req_payload_type t;
      t.req_type = code;
      t.value    = v;
      t.left     = IDX_BITS'(l);
      t.right    = IDX_BITS'(r);
      pending_requests.insert(pending_requests.size(), t);
      if (code == REQ_CLEAR) planned_count = 0;
      else if (code == REQ_LOAD && planned_count < CAPACITY) planned_count++;
   endtask

   function automatic logic signed [VALUE_BITS-1:0] random_value();
      case ($urandom_range(0, 5))
         1: return $urandom_range(0, 6) - 3;
         2: return VALUE_MAX;
         3: return VALUE_MIN;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_random_query();
      int l;
      int r;
      l = $urandom_range(0, IDX_MAX);
      r = $urandom_range(0, IDX_MAX);
      case ($urandom_range(0, 9))
         0: ;
         1: begin
            l = $urandom_range(1, IDX_MAX);
            r = $urandom_range(0, l - 1);
         end
         2: begin
            if (planned_count > 0) begin
               l = $urandom_range(0, planned_count - 1);
               r = $urandom_range(l, IDX_MAX);
            end
         end
         default: begin
            if (planned_count > 0) begin
               l = $urandom_range(0, planned_count - 1);
               r = $urandom_range(l, planned_count - 1);
            end
         end
      endcase
      add_request(REQ_QUERY, $urandom, l, r);
   endtask

   task automatic add_random_mix(input int count);
      int added;
      int sel;
      int m;
      added = 0;
      while (added < count) begin
         sel = $urandom_range(0, 19);
         if (sel == 0) begin
            add_request(REQ_CLEAR, $urandom, $urandom_range(0, IDX_MAX),
                        $urandom_range(0, IDX_MAX));
            added++;
         end else if (sel == 1) begin
            add_request(REQ_UNUSED, $urandom, $urandom_range(0, IDX_MAX),
                        $urandom_range(0, IDX_MAX));
            added++;
         end else if (sel < 9) begin
            m = $urandom_range(1, 24);
            repeat (m) add_request(REQ_LOAD, random_value(), $urandom_range(0, IDX_MAX),
                                   $urandom_range(0, IDX_MAX));
            added += m;
         end else begin
            m = $urandom_range(1, 8);
            repeat (m) add_random_query();
            added += m;
         end
      end
   endtask

   task automatic drain();
      while (pending_requests.size() != 0 || req_valid || expected_minima.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      add_request(REQ_QUERY, 0, 0, 0);
      add_request(REQ_LOAD, VALUE_MAX, 0, 0);
      add_request(REQ_LOAD, VALUE_MIN, 0, 0);
      add_request(REQ_LOAD, 0, 0, 0);
      add_request(REQ_LOAD, -1, 0, 0);
      add_request(REQ_LOAD, VALUE_MIN, 0, 0);
      add_request(REQ_LOAD, 5, 0, 0);
      add_request(REQ_QUERY, 0, 0, 5);
      add_request(REQ_QUERY, 0, 2, 1);
      add_request(REQ_QUERY, 0, 6, 6);
      add_request(REQ_QUERY, 0, 3, IDX_MAX);
      add_request(REQ_QUERY, 0, 0, 0);
      add_request(REQ_QUERY, 0, IDX_MAX, IDX_MAX);
      add_request(REQ_UNUSED, -1, IDX_MAX, IDX_MAX);
      add_request(REQ_QUERY, 0, 0, IDX_MAX);
      add_request(REQ_CLEAR, 0, 0, 0);
      add_request(REQ_QUERY, 0, 0, 0);
      add_request(REQ_LOAD, 7, 0, 0);
      add_request(REQ_LOAD, 7, 0, 0);
      add_request(REQ_LOAD, 7, 0, 0);
      add_request(REQ_QUERY, 0, 0, 2);
      add_request(REQ_QUERY, 0, 1, 2);
      add_request(REQ_QUERY, 0, 0, 1);
      add_random_mix(110);
      drain();

      send_idle_pct = 64;
      rsp_idle_pct  = 9;
      add_random_mix(110);
      drain();

      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      add_random_mix(110);
      add_request(REQ_CLEAR, 0, 0, 0);
      repeat (24) add_request(REQ_LOAD, random_value(), $urandom_range(0, IDX_MAX),
                              $urandom_range(0, IDX_MAX));
      add_request(REQ_QUERY, 0, 0, IDX_MAX);
      add_request(REQ_QUERY, 0, IDX_MAX, IDX_MAX);
      add_request(REQ_QUERY, 0, CAPACITY / 2, IDX_MAX);
      add_request(REQ_QUERY, 0, 0, CAPACITY / 2 - 1);
      repeat (20) add_random_query();
      drain();

      repeat (TAIL_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
